// ----- rtl/core/pfa_pkg.sv -----
// Shared types and constants of the two-objective Pareto archive.
// Used by the cell, the top level and the port checker; no dependencies.
package pfa_pkg;

   localparam int CAPACITY   = 64;
   localparam int COST_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int READ_W     = 6;
   localparam int FIELD_CNT_W = 7;
   localparam int RD_CMP_W   = (CNT_W > READ_W) ? CNT_W : READ_W;

   // request tdata layout
   localparam int REQ_DATA_W = 72;
   // response tdata layout
   localparam int RSP_DATA_W      = 88;
   localparam int RSP_ACC_BIT     = 0;
   localparam int RSP_REM_LO      = 1;
   localparam int RSP_CNT_LO      = 8;
   localparam int RSP_OVF_BIT     = 15;
   localparam int RSP_RDV_BIT     = 16;
   localparam int RSP_USED_W      = 81;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CMP,
      CELL_SHIFT,
      CELL_PLACE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_SHIFT,
      ST_DONE
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type                   op;
      logic signed [COST_WIDTH-1:0]  new_first;
      logic signed [COST_WIDTH-1:0]  new_second;
      logic [CNT_W-1:0]              count;
      logic [READ_W-1:0]             read_index;
   } cmd_type;

   // handed between neighboring cells
   typedef struct packed {
      logic signed [COST_WIDTH-1:0]  first;
      logic signed [COST_WIDTH-1:0]  second;
      logic                          lt;
      logic                          rem;
   } link_type;

   // per-cell status back to the controller
   typedef struct packed {
      logic                          dom;
      logic [COST_WIDTH-1:0]         rd_first;
      logic [COST_WIDTH-1:0]         rd_second;
   } tap_type;

endpackage

// ----- rtl/core/pfa_cell.sv -----
// One archive slot: holds an entry and its compare flags.
// Compares against the broadcast point, shifts left on removal, right on insert. Uses pfa_pkg.
module pfa_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  pfa_pkg::cmd_type           cmd,
   input  logic [pfa_pkg::IDX_W-1:0]  index,
   input  pfa_pkg::link_type          left_in,
   input  pfa_pkg::link_type          right_in,
   output pfa_pkg::link_type          link_out,
   output pfa_pkg::tap_type           tap_out
);

   logic signed [pfa_pkg::COST_WIDTH-1:0] first_ff, first_in;
   logic signed [pfa_pkg::COST_WIDTH-1:0] second_ff, second_in;
   logic lt_ff, lt_in;
   logic rem_ff, rem_in;
   logic dom_ff, dom_in;
   logic occ;
   logic no_worse;
   logic covers;
   logic hit;

   assign occ      = pfa_pkg::CNT_W'(index) < cmd.count;
   assign no_worse = (first_ff <= cmd.new_first) && (second_ff <= cmd.new_second);
   assign covers   = (cmd.new_first <= first_ff) && (cmd.new_second <= second_ff);
   assign hit      = pfa_pkg::RD_CMP_W'(index) == pfa_pkg::RD_CMP_W'(cmd.read_index);

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      lt_in     = lt_ff;
      rem_in    = rem_ff;
      dom_in    = dom_ff;
      case (cmd.op)
         pfa_pkg::CELL_CMP: begin
            lt_in  = occ && (first_ff < cmd.new_first);
            dom_in = occ && no_worse;
            rem_in = occ && !no_worse && covers;
         end
         pfa_pkg::CELL_SHIFT: begin
            // cells at or past the insert slot pull from the right
            if (!lt_ff) begin
               first_in  = right_in.first;
               second_in = right_in.second;
               rem_in    = right_in.rem;
            end
         end
         pfa_pkg::CELL_PLACE: begin
            if (!lt_ff) begin
               if (left_in.lt) begin
                  first_in  = cmd.new_first;
                  second_in = cmd.new_second;
               end else begin
                  first_in  = left_in.first;
                  second_in = left_in.second;
               end
            end
            rem_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff  <= 1'b0;
         rem_ff <= 1'b0;
         dom_ff <= 1'b0;
      end else begin
         lt_ff  <= lt_in;
         rem_ff <= rem_in;
         dom_ff <= dom_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign link_out.first  = first_ff;
   assign link_out.second = second_ff;
   assign link_out.lt     = lt_ff;
   assign link_out.rem    = rem_ff;

   assign tap_out.dom       = dom_ff;
   assign tap_out.rd_first  = hit ? first_ff : '0;
   assign tap_out.rd_second = hit ? second_ff : '0;

endmodule

// ----- rtl/core/pareto_frontier_archive.sv -----
// Top level of the two-objective Pareto archive: controller plus a chain of pfa_cell slots.
// Depends on pfa_pkg and pfa_cell.
//
// Keeps up to 64 mutually non-dominated (first_cost, second_cost) points sorted by first cost.
// One request is worked at a time. A read passes the compare and done states; an insert
// passes compare, one shift step per removed entry, a step that places or drops the point,
// and done, as the chain closes the gap left by removed entries one slot per cycle. The
// result sits in an output register, so the next request is taken while it waits. The
// archive needs no initialization pass after reset; entries beyond the count are never read.
module pareto_frontier_archive (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] first_cost, [63:32] second_cost, [69:64] read_index, rest zero
   input  logic [pfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] accepted, [7:1] removed_count, [14:8] point_count, [15] overflow,
   // [16] read_valid, [48:17] read_first, [80:49] read_second, rest zero
   output logic [pfa_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int N = pfa_pkg::CAPACITY;
   localparam int CW = pfa_pkg::COST_WIDTH;

   pfa_pkg::state_type state_ff, state_in;

   logic                             type_ff, type_in;
   logic signed [CW-1:0]             a_ff, a_in;
   logic signed [CW-1:0]             b_ff, b_in;
   logic [pfa_pkg::READ_W-1:0]       ridx_ff, ridx_in;
   logic [pfa_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [pfa_pkg::CNT_W-1:0]        removed_ff, removed_in;
   logic                             acc_ff, acc_in;
   logic                             ovf_ff, ovf_in;
   logic                             rdv_ff, rdv_in;
   logic [CW-1:0]                    rdf_ff, rdf_in;
   logic [CW-1:0]                    rds_ff, rds_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   pfa_pkg::cmd_type                 cmd;
   pfa_pkg::cell_op_type             op;
   pfa_pkg::link_type                links [N];
   pfa_pkg::link_type                lefts [N];
   pfa_pkg::link_type                rights [N];
   pfa_pkg::tap_type                 taps [N];

   logic                             req_xfer;
   logic                             slot_free;
   logic                             dom_any;
   logic                             rem_any;
   logic                             read_hit;
   logic [CW-1:0]                    read_first_all;
   logic [CW-1:0]                    read_second_all;

   assign req_xfer  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign read_hit  = pfa_pkg::RD_CMP_W'(ridx_ff) < pfa_pkg::RD_CMP_W'(count_ff);

   assign cmd.op         = op;
   assign cmd.new_first  = a_ff;
   assign cmd.new_second = b_ff;
   assign cmd.count      = count_ff;
   assign cmd.read_index = ridx_ff;

   // neighbor wiring: slot 0 sees a left that is always "smaller"
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            lefts[i] = '{first: '0, second: '0, lt: 1'b1, rem: 1'b0};
         end else begin
            lefts[i] = links[i-1];
         end
         if (i == N - 1) begin
            rights[i] = '0;
         end else begin
            rights[i] = links[i+1];
         end
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      pfa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .index    (pfa_pkg::IDX_W'(g)),
         .left_in  (lefts[g]),
         .right_in (rights[g]),
         .link_out (links[g]),
         .tap_out  (taps[g])
      );
   end

   always_comb begin
      dom_any         = 1'b0;
      rem_any         = 1'b0;
      read_first_all  = '0;
      read_second_all = '0;
      for (int i = 0; i < N; i++) begin
         dom_any         = dom_any | taps[i].dom;
         rem_any         = rem_any | links[i].rem;
         read_first_all  = read_first_all | taps[i].rd_first;
         read_second_all = read_second_all | taps[i].rd_second;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = pfa_pkg::ST_CMP;
            end
         end
         pfa_pkg::ST_CMP: begin
            if (type_ff == pfa_pkg::REQ_READ) begin
               state_in = pfa_pkg::ST_DONE;
            end else begin
               state_in = pfa_pkg::ST_SHIFT;
            end
         end
         pfa_pkg::ST_SHIFT: begin
            if (dom_any || !rem_any) begin
               state_in = pfa_pkg::ST_DONE;
            end
         end
         pfa_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = pfa_pkg::ST_IDLE;
            end
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_tready   = 1'b0;
      op           = pfa_pkg::CELL_HOLD;
      type_in      = type_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ridx_in      = ridx_ff;
      count_in     = count_ff;
      removed_in   = removed_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rdv_in       = rdv_ff;
      rdf_in       = rdf_ff;
      rds_in       = rds_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               type_in    = req_tuser;
               a_in       = req_tdata[CW-1:0];
               b_in       = req_tdata[2*CW-1:CW];
               ridx_in    = req_tdata[2*CW+pfa_pkg::READ_W-1:2*CW];
               removed_in = '0;
               acc_in     = 1'b0;
               ovf_in     = 1'b0;
               rdv_in     = 1'b0;
               rdf_in     = '0;
               rds_in     = '0;
            end
         end
         pfa_pkg::ST_CMP: begin
            if (type_ff == pfa_pkg::REQ_READ) begin
               rdv_in = read_hit;
               rdf_in = read_hit ? read_first_all : '0;
               rds_in = read_hit ? read_second_all : '0;
            end else begin
               op = pfa_pkg::CELL_CMP;
            end
         end
         pfa_pkg::ST_SHIFT: begin
            if (dom_any) begin
               op = pfa_pkg::CELL_HOLD;
            end else if (rem_any) begin
               // close the gap of one removed entry at the insert slot
               op         = pfa_pkg::CELL_SHIFT;
               count_in   = count_ff - pfa_pkg::CNT_W'(1);
               removed_in = removed_ff + pfa_pkg::CNT_W'(1);
            end else if (removed_ff == '0 && count_ff == pfa_pkg::CNT_W'(N)) begin
               ovf_in = 1'b1;
            end else begin
               op       = pfa_pkg::CELL_PLACE;
               count_in = count_ff + pfa_pkg::CNT_W'(1);
               acc_in   = 1'b1;
            end
         end
         pfa_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {
                  (pfa_pkg::RSP_DATA_W - pfa_pkg::RSP_USED_W)'(0),
                  rds_ff,
                  rdf_ff,
                  rdv_ff,
                  ovf_ff,
                  pfa_pkg::FIELD_CNT_W'(count_ff),
                  pfa_pkg::FIELD_CNT_W'(removed_ff),
                  acc_ff
               };
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      ridx_ff     <= ridx_in;
      removed_ff  <= removed_in;
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
      rdv_ff      <= rdv_in;
      rdf_ff      <= rdf_in;
      rds_ff      <= rds_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/pfa_checker.sv -----
// Port-level checks of the Pareto archive, bound to the top level.
// Depends on pfa_pkg and pareto_frontier_archive.
module pfa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pfa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic [pfa_pkg::FIELD_CNT_W-1:0] rsp_removed;
   logic [pfa_pkg::FIELD_CNT_W-1:0] rsp_count;

   assign rsp_removed = rsp_tdata[pfa_pkg::RSP_REM_LO +: pfa_pkg::FIELD_CNT_W];
   assign rsp_count   = rsp_tdata[pfa_pkg::RSP_CNT_LO +: pfa_pkg::FIELD_CNT_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one request in flight: ready drops right after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= pfa_pkg::FIELD_CNT_W'(pfa_pkg::CAPACITY))
      else $error("point count above capacity");

   // removing entries means the point went in
   a_removed_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_removed != '0 |-> rsp_tdata[pfa_pkg::RSP_ACC_BIT]
         && !rsp_tdata[pfa_pkg::RSP_OVF_BIT])
      else $error("removal without acceptance");

   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[pfa_pkg::RSP_RDV_BIT] |-> !rsp_tdata[pfa_pkg::RSP_ACC_BIT]
         && !rsp_tdata[pfa_pkg::RSP_OVF_BIT] && rsp_removed == '0)
      else $error("read result carries insert status");

endmodule

bind pareto_frontier_archive pfa_checker u_pfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/pareto_frontier_archive_check.sv -----
// Response checker for pareto_frontier_archive: watches the request and response
// stream ports, keeps its own copy of the archive and compares every response.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pareto_frontier_archive_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // [31:0] first_cost, [63:32] second_cost, [69:64] read_index
   input  logic [pfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] accepted, [7:1] removed_count, [14:8] point_count, [15] overflow,
   // [16] read_valid, [48:17] read_first, [80:49] read_second
   input  logic [pfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output int                                 fail_count,
   output int                                 open_count
);
   import pfa_pkg::*;

   localparam int RD_FIRST_LO  = RSP_RDV_BIT + 1;
   localparam int RD_SECOND_LO = RD_FIRST_LO + COST_WIDTH;

   typedef logic signed [COST_WIDTH-1:0] cost_type;

   typedef struct packed {
      logic                   accepted;
      logic [FIELD_CNT_W-1:0] removed;
      logic [FIELD_CNT_W-1:0] count;
      logic                   overflow;
      logic                   read_valid;
      cost_type               read_first;
      cost_type               read_second;
   } reply_type;

   cost_type  arch_first [CAPACITY];
   cost_type  arch_second [CAPACITY];
   int        arch_total;
   reply_type due_replies [$];
   reply_type want_reply;
   reply_type new_reply;

   // one request against the archive copy; updates it and returns the response
   task automatic archive_apply(input logic kind, input cost_type a, input cost_type b,
                                input logic [READ_W-1:0] idx, output reply_type r);
      int  n;
      int  kept;
      int  pos;
      int  removed;
      bit  dominated;
      r = '0;
      n = arch_total;
      if (kind == REQ_INSERT) begin
         dominated = 1'b0;
         removed = 0;
         for (int i = 0; i < n; i++) begin
            if (arch_first[i] <= a && arch_second[i] <= b)
               dominated = 1'b1;
            else if (a <= arch_first[i] && b <= arch_second[i])
               removed++;
         end
         if (dominated) begin
            removed = 0;
         end else if (removed == 0 && n >= CAPACITY) begin
            r.overflow = 1'b1;
         end else begin
            // compact out the dominated entries, remember where the point goes
            kept = 0;
            pos = 0;
            for (int i = 0; i < n; i++) begin
               if (a <= arch_first[i] && b <= arch_second[i])
                  continue;
               arch_first[kept] = arch_first[i];
               arch_second[kept] = arch_second[i];
               if (arch_first[i] < a)
                  pos = kept + 1;
               kept++;
            end
            for (int i = kept; i > pos; i--) begin
               arch_first[i] = arch_first[i-1];
               arch_second[i] = arch_second[i-1];
            end
            arch_first[pos] = a;
            arch_second[pos] = b;
            n = kept + 1;
            arch_total = n;
            r.accepted = 1'b1;
         end
         r.removed = FIELD_CNT_W'(removed);
      end else if (idx < n) begin
         r.read_valid = 1'b1;
         r.read_first = arch_first[idx];
         r.read_second = arch_second[idx];
      end
      r.count = FIELD_CNT_W'(n);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // response side first: a request taken at this edge cannot answer before later edges
   always @(posedge clock) begin
      if (reset) begin
         arch_total = 0;
         due_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response transfer with nothing outstanding", $time);
            end else begin
               want_reply = due_replies.pop_front();
               check_field("accepted", 64'(want_reply.accepted),
                           64'(rsp_tdata[RSP_ACC_BIT]));
               check_field("removed_count", 64'(want_reply.removed),
                           64'(rsp_tdata[RSP_REM_LO +: FIELD_CNT_W]));
               check_field("point_count", 64'(want_reply.count),
                           64'(rsp_tdata[RSP_CNT_LO +: FIELD_CNT_W]));
               check_field("overflow", 64'(want_reply.overflow),
                           64'(rsp_tdata[RSP_OVF_BIT]));
               check_field("read_valid", 64'(want_reply.read_valid),
                           64'(rsp_tdata[RSP_RDV_BIT]));
               check_field("read_first", 64'(want_reply.read_first),
                           64'($signed(rsp_tdata[RD_FIRST_LO +: COST_WIDTH])));
               check_field("read_second", 64'(want_reply.read_second),
                           64'($signed(rsp_tdata[RD_SECOND_LO +: COST_WIDTH])));
            end
         end
         if (req_tvalid && req_tready) begin
            archive_apply(req_tuser, req_tdata[0 +: COST_WIDTH],
                          req_tdata[COST_WIDTH +: COST_WIDTH],
                          req_tdata[2*COST_WIDTH +: READ_W], new_reply);
            due_replies = {due_replies, new_reply};
         end
      end
      open_count <= due_replies.size();
   end

endmodule

// ----- verif/pareto_frontier_archive_test.sv -----
// Testbench top for pareto_frontier_archive: clock, reset, request stimulus and
// response back-pressure; checking is done by pareto_frontier_archive_check.
// Depends on pfa_pkg, pareto_frontier_archive and pareto_frontier_archive_check.
`timescale 1ns / 1ps

module pareto_frontier_archive_test;
   import pfa_pkg::*;

   typedef logic signed [COST_WIDTH-1:0] cost_type;

   localparam cost_type COST_MAX = {1'b0, {(COST_WIDTH-1){1'b1}}};
   localparam cost_type COST_MIN = {1'b1, {(COST_WIDTH-1){1'b0}}};
   localparam int       MAX_FRONT = 80;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   int                     fail_count;
   int                     open_count;

   bit       quiet = 1'b0;     // no idling on either side
   bit       hold_rsp = 1'b0;  // asks the response side for one long stall
   cost_type front_first [MAX_FRONT];
   cost_type front_second [MAX_FRONT];
   int       order [MAX_FRONT];

   pareto_frontier_archive uut (.*);

   pareto_frontier_archive_check archive_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("pareto_frontier_archive_test: errors");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one request and hold it until the transfer; tvalid stays up when no gap follows
   task automatic send_request(input logic kind, input cost_type first,
                               input cost_type second, input logic [READ_W-1:0] index);
      int gap;
      req_tuser <= kind;
      req_tdata <= {{(REQ_DATA_W - 2*COST_WIDTH - READ_W){1'b0}}, index, second, first};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = quiet ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic insert_point(input cost_type first, input cost_type second);
      send_request(REQ_INSERT, first, second, READ_W'($urandom));
   endtask

   task automatic read_entry(input logic [READ_W-1:0] index);
      send_request(REQ_READ, $urandom, $urandom, index);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   // far above or far to the right of every front, so the archive never gets stuck
   task automatic add_noise();
      if ($urandom_range(0, 1))
         insert_point($urandom, $urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
      else
         insert_point($urandom_range(32'h7FFF_FFFF, 32'h4000_0000), $urandom);
   endtask

   // one staircase of mutually non-dominated points, lower than every earlier one
   task automatic run_episode(input int ep);
      int npts;
      int step;
      int xl;
      int diag;
      int j;
      int pick;
      int tmp;
      int k;
      xl = -(1 << 27) - ep * (1 << 22);
      diag = (1 << 28) - ep * (1 << 27);
      npts = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40) : $urandom_range(66, 76);
      step = ($urandom_range(0, 2) == 0) ? $urandom_range(8, 64) : $urandom_range(8, 1 << 19);
      for (int i = 0; i < npts; i++) begin
         front_first[i] = xl + i * step + $urandom_range(0, step / 4);
         front_second[i] = diag - front_first[i];
         order[i] = i;
      end
      pick = $urandom_range(0, 2);
      if (pick == 1) begin
         for (int i = 0; i < npts; i++)
            order[i] = npts - 1 - i;
      end else if (pick == 2) begin
         for (int i = npts - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
      end
      if (ep == 1)
         hold_rsp = 1'b1;
      quiet = (ep == 3);
      for (int i = 0; i < npts; i++) begin
         k = order[i];
         insert_point(front_first[k], front_second[k]);
         pick = $urandom_range(0, 15);
         if (pick < 4)
            read_entry(READ_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 7)));
         else if (pick < 6)
            add_noise();
         else if (pick == 6)
            insert_point(front_first[k], front_second[k]);
         else if (pick == 7)
            insert_point(front_first[k], front_second[k] - 1);
         else if (pick == 8)
            insert_point(front_first[k] + 1, front_second[k] + 1);
      end
      // between two neighbors: removes nothing, so a full archive overflows
      j = $urandom_range(0, npts - 2);
      insert_point((front_first[j] + front_first[j+1]) >>> 1,
                   (front_second[j] + front_second[j+1]) >>> 1);
      // corner point that removes the whole staircase
      if ($urandom_range(0, 1))
         insert_point(front_first[0] - 1, front_second[npts-1] - 1);
      for (int i = 0; i < 4; i++)
         read_entry(READ_W'($urandom_range(0, 63)));
      quiet = 1'b0;
      wait_drained();
   endtask

   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall_left = 400;
            run_left = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            run_left = $urandom_range(1, 24);
            if (!quiet)
               stall_left = idle_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            run_left--;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= REQ_INSERT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      read_entry(0);                   // empty archive
      insert_point(0, 0);
      insert_point(0, 0);              // equal point is dropped
      insert_point(10, 10);            // dominated
      insert_point(COST_MIN, COST_MAX);
      insert_point(COST_MAX, COST_MIN);
      insert_point(0, -5);             // same first cost, better second: replaces
      insert_point(5, -10);
      insert_point(-3, 2);
      read_entry(1);
      read_entry(4);
      insert_point(-4, -20);           // removes three entries
      insert_point(COST_MAX, COST_MAX);
      insert_point(COST_MIN, COST_MAX);
      for (int i = 0; i < 4; i++)
         read_entry(READ_W'(i));
      read_entry(63);
      wait_drained();

      for (int ep = 0; ep < 8; ep++)
         run_episode(ep);

      repeat (80) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("pareto_frontier_archive_test: clean");
      else
         $display("pareto_frontier_archive_test: errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/pfa_pkg.sv
rtl/core/pfa_cell.sv
rtl/core/pareto_frontier_archive.sv
rtl/core/pfa_checker.sv
verif/pareto_frontier_archive_check.sv
verif/pareto_frontier_archive_test.sv
